// ===== hw/rtl/fcds_pkg.sv =====
package fcds_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int WIDE_W       = 64;

   // result fields packed from the lowest bit up, padded to whole bytes
   localparam int RSP_FIELDS_W = 227;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_QUOT_DIV = 2'd2;

   // shared unit operations
   localparam logic [1:0] OP_DIV = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;

   typedef struct packed {
      logic              start;
      logic [1:0]        op;
      logic [WIDE_W-1:0] x;
      logic [WIDE_W-1:0] y;
   } unit_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] quo;
      logic [WIDE_W-1:0] rem;
   } unit_rsp_type;

endpackage

// ===== hw/rtl/fraction_common_den_sum_quotient.sv =====
// Fraction pair reducer: common denominator, reduced sum and reduced quotient.
// req channel: one transfer carries two fractions a and b; tdata holds
// a_numerator, a_denominator, b_numerator, b_denominator, each IN_WIDTH bits,
// from the lowest bit up.
// rsp channel: one transfer per request with the scaled numerators, the
// common denominator, the reduced sum and quotient and a status code.
// All divides and multiplies run through one shared shift/subtract unit that
// divides or multiplies one bit a cycle; the sum is added in the sequencer.
// A request runs the Euclid steps of five gcds and 14 divides and multiplies.
// A zero denominator skips the arithmetic: the sequencer goes straight to its
// done state, and the result is then registered in the output register.
// req_tready is high only while the sequencer is idle and the output register
// is free; a finished result is held in the output register, so a stalled
// receiver stops the block from taking the next request until the result is
// taken. Synchronous reset empties the output register and returns the
// sequencer to idle.
module fraction_common_den_sum_quotient #(
   parameter int IN_WIDTH = fcds_pkg::IN_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator
   input  logic [((4*IN_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // a_scaled_num, b_scaled_num, common_den, sum_num, sum_den, quot_num,
   // quot_den, status
   output logic [fcds_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   fcds_pkg::unit_cmd_type cmd;
   fcds_pkg::unit_rsp_type rsp;
   logic         idle, finish;
   logic [fcds_pkg::RSP_DATA_W-1:0] result;
   logic         valid_ff, valid_in;
   logic [fcds_pkg::RSP_DATA_W-1:0] data_ff, data_in;

   fcds_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(rsp));

   fcds_seq #(.IN_WIDTH(IN_WIDTH)) u_seq (
      .clock(clock), .reset(reset),
      .start(req_tvalid && req_tready),
      .operands(req_tdata[4*IN_WIDTH-1:0]),
      .idle(idle), .finish(finish), .result(result),
      .cmd(cmd), .rsp(rsp)
   );

   assign req_tready = idle && !valid_ff;

   // output register
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_tvalid && rsp_tready) valid_in = 1'b0;
      if (finish) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
endmodule

// ===== hw/rtl/fcds_alu.sv =====
// shared shift/subtract unit: restoring divide or shift-add multiply, one bit a cycle
module fcds_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  fcds_pkg::unit_cmd_type cmd,
   output fcds_pkg::unit_rsp_type rsp
);
   localparam int W  = fcds_pkg::WIDE_W;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [1:0]    op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;   // remainder or product
   logic [W-1:0]  q_ff, q_in;       // quotient or multiplier shift
   logic [W-1:0]  d_ff, d_in;       // divisor or multiplicand
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      trial   = '0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CW'(W);
         acc_in  = '0;
         q_in    = cmd.x;
         d_in    = cmd.y;
      end else if (busy_ff) begin
         if (op_ff == fcds_pkg::OP_DIV) begin
            // shift in next dividend bit and try subtracting
            trial = {acc_ff, q_ff[W-1]} - {1'b0, d_ff};
            if (!trial[W]) begin
               acc_in = trial[W-1:0];
               q_in   = {q_ff[W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[W-2:0], q_ff[W-1]};
               q_in   = {q_ff[W-2:0], 1'b0};
            end
         end else begin
            // add multiplicand when low multiplier bit set
            if (q_ff[0]) acc_in = acc_ff + d_ff;
            q_in = q_ff >> 1;
            d_in = d_ff << 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= fcds_pkg::OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   always_comb begin
      rsp.done = done_ff;
      rsp.quo  = (op_ff == fcds_pkg::OP_DIV) ? q_ff : acc_ff;
      rsp.rem  = acc_ff;
   end
endmodule

// ===== hw/rtl/fcds_seq.sv =====
// sequencer: runs the reductions and scalings through the shared unit
module fcds_seq #(
   parameter int IN_WIDTH = fcds_pkg::IN_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [4*IN_WIDTH-1:0]  operands,
   output logic                   idle,
   output logic                   finish,
   output logic [fcds_pkg::RSP_DATA_W-1:0] result,
   output fcds_pkg::unit_cmd_type cmd,
   input  fcds_pkg::unit_rsp_type rsp
);
   localparam int W = fcds_pkg::WIDE_W;

   // steps; each gcd is a loop of division steps
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_GCD   = 5'd1;   // euclid loop on gx, gy
   localparam logic [4:0] S_GWAIT = 5'd2;
   localparam logic [4:0] S_DIV   = 5'd3;   // divide div_x by g (a gcd or a denominator)
   localparam logic [4:0] S_DWAIT = 5'd4;
   localparam logic [4:0] S_NEXT  = 5'd5;   // dispatch next task
   localparam logic [4:0] S_MUL   = 5'd6;
   localparam logic [4:0] S_MWAIT = 5'd7;
   localparam logic [4:0] S_DONE  = 5'd8;

   logic [4:0]   st_ff, st_in;
   logic [3:0]   task_ff, task_in;
   logic [W-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [W-1:0] l_ff, l_in, as_ff, as_in, bs_ff, bs_in;
   logic [W-1:0] sn_ff, sn_in, sd_ff, sd_in, qn_ff, qn_in, qd_ff, qd_in;
   logic [W-1:0] gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in, t_ff, t_in;
   logic [1:0]   status_ff, status_in;
   logic [W-1:0] div_x, mul_x, mul_y;
   logic [IN_WIDTH-1:0] oan, oad, obn, obd;

   assign oan = operands[IN_WIDTH-1:0];
   assign oad = operands[2*IN_WIDTH-1:IN_WIDTH];
   assign obn = operands[3*IN_WIDTH-1:2*IN_WIDTH];
   assign obd = operands[4*IN_WIDTH-1:3*IN_WIDTH];

   // tasks: 0 reduce a, 1 reduce b, 2 gcd of dens, 3 l, 4 as, 5 bs,
   // 6 reduce sum, 7 reduce quotient, 8 finished
   // task number and divide sub-index select operands
   logic [1:0] sub_ff, sub_in;

   always_comb begin
      div_x = '0;
      case (task_ff)
         4'd0:    div_x = (sub_ff == 2'd0) ? an_ff : ad_ff;
         4'd1:    div_x = (sub_ff == 2'd0) ? bn_ff : bd_ff;
         4'd3:    div_x = ad_ff;
         4'd4:    div_x = l_ff;
         4'd5:    div_x = l_ff;
         4'd6:    div_x = (sub_ff == 2'd0) ? sn_ff : sd_ff;
         4'd7:    div_x = (sub_ff == 2'd0) ? qn_ff : qd_ff;
         default: div_x = '0;
      endcase
      mul_x = t_ff;
      case (task_ff)
         4'd3:    mul_y = bd_ff;
         4'd4:    mul_y = an_ff;
         4'd5:    mul_y = bn_ff;
         default: mul_y = '0;
      endcase
   end

   always_comb begin
      st_in = st_ff; task_in = task_ff; sub_in = sub_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      l_in = l_ff; as_in = as_ff; bs_in = bs_ff;
      sn_in = sn_ff; sd_in = sd_ff; qn_in = qn_ff; qd_in = qd_ff;
      gx_in = gx_ff; gy_in = gy_ff; g_in = g_ff; t_in = t_ff;
      status_in = status_ff;
      cmd = '0;
      finish = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               an_in = W'(oan); ad_in = W'(oad);
               bn_in = W'(obn); bd_in = W'(obd);
               l_in = '0; as_in = '0; bs_in = '0; sn_in = '0; sd_in = '0;
               qn_in = '0; qd_in = '0;
               if (oad == '0 || obd == '0) begin
                  status_in = fcds_pkg::STATUS_ZERO_DEN;
                  st_in     = S_DONE;
               end else begin
                  status_in = fcds_pkg::STATUS_OK;
                  task_in   = 4'd0;
                  gx_in     = W'(oan);
                  gy_in     = W'(oad);
                  st_in     = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (gy_ff == '0) begin
               g_in   = gx_ff;
               sub_in = 2'd0;
               // the denominator gcd only feeds the lcm
               st_in  = (task_ff == 4'd2) ? S_NEXT : S_DIV;
               if (gx_ff == '0) st_in = S_NEXT;
            end else begin
               cmd.start = 1'b1; cmd.op = fcds_pkg::OP_DIV;
               cmd.x = gx_ff; cmd.y = gy_ff;
               st_in = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (rsp.done) begin
               gx_in = gy_ff;
               gy_in = rsp.rem;
               st_in = S_GCD;
            end
         end
         S_DIV: begin
            cmd.start = 1'b1; cmd.op = fcds_pkg::OP_DIV;
            cmd.x = div_x; cmd.y = g_ff;
            st_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (rsp.done) begin
               case (task_ff)
                  4'd0: if (sub_ff == 2'd0) an_in = rsp.quo; else ad_in = rsp.quo;
                  4'd1: if (sub_ff == 2'd0) bn_in = rsp.quo; else bd_in = rsp.quo;
                  4'd6: if (sub_ff == 2'd0) sn_in = rsp.quo; else sd_in = rsp.quo;
                  4'd7: if (sub_ff == 2'd0) qn_in = rsp.quo; else qd_in = rsp.quo;
                  default: t_in = rsp.quo;
               endcase
               if (task_ff == 4'd3 || task_ff == 4'd4 || task_ff == 4'd5) begin
                  st_in = S_MUL;
               end else if (sub_ff == 2'd0) begin
                  sub_in = 2'd1;
                  st_in  = S_DIV;
               end else begin
                  st_in = S_NEXT;
               end
            end
         end
         S_MUL: begin
            cmd.start = 1'b1; cmd.op = fcds_pkg::OP_MUL;
            cmd.x = mul_x; cmd.y = mul_y;
            st_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (rsp.done) begin
               case (task_ff)
                  4'd3:    l_in  = rsp.quo;
                  4'd4:    as_in = rsp.quo;
                  default: bs_in = rsp.quo;
               endcase
               st_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // advance to the next task and prime its operands
            task_in = task_ff + 4'd1;
            sub_in  = 2'd1;
            case (task_ff)
               4'd0: begin
                  gx_in = bn_ff; gy_in = bd_ff; st_in = S_GCD;
               end
               4'd1: begin
                  gx_in = ad_ff; gy_in = bd_ff; st_in = S_GCD;
               end
               4'd2: st_in = S_DIV;        // l = (ad / g) * bd
               4'd3: begin
                  g_in = ad_ff; st_in = S_DIV;   // as = an * (l / ad)
               end
               4'd4: begin
                  g_in = bd_ff; st_in = S_DIV;   // bs = bn * (l / bd)
               end
               4'd5: begin
                  sn_in = as_ff + bs_ff; sd_in = l_ff;
                  gx_in = as_ff + bs_ff; gy_in = l_ff;
                  st_in = S_GCD;
               end
               4'd6: begin
                  if (bs_ff == '0) begin
                     status_in = fcds_pkg::STATUS_QUOT_DIV;
                     st_in     = S_DONE;
                  end else begin
                     qn_in = as_ff; qd_in = bs_ff;
                     gx_in = as_ff; gy_in = bs_ff;
                     st_in = S_GCD;
                  end
               end
               default: st_in = S_DONE;
            endcase
         end
         S_DONE: begin
            finish = 1'b1;
            st_in  = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         task_ff   <= '0;
         sub_ff    <= '0;
         status_ff <= fcds_pkg::STATUS_OK;
      end else begin
         st_ff     <= st_in;
         task_ff   <= task_in;
         sub_ff    <= sub_in;
         status_ff <= status_in;
      end
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      l_ff <= l_in; as_ff <= as_in; bs_ff <= bs_in;
      sn_ff <= sn_in; sd_ff <= sd_in; qn_ff <= qn_in; qd_ff <= qd_in;
      gx_ff <= gx_in; gy_ff <= gy_in; g_ff <= g_in; t_ff <= t_in;
   end

   assign idle = (st_ff == S_IDLE);

   // result fields, lowest first, padded to whole bytes
   assign result = {5'd0, status_ff, qd_ff[31:0], qn_ff[31:0], sd_ff[31:0],
                    sn_ff[32:0], l_ff[31:0], bs_ff[31:0], as_ff[31:0]};
endmodule
